// ===== sv/sdsh_pkg.sv =====
package sdsh_pkg;

  localparam int BlockBytes = 512;
  localparam int BlkShift = $clog2(BlockBytes);
  localparam int BcW = 10;
  localparam int FifoDepth = 4;

  localparam logic [2:0] ReqInit = 3'd0;
  localparam logic [2:0] ReqRead = 3'd1;
  localparam logic [2:0] ReqWrite = 3'd2;
  localparam logic [2:0] ReqCap = 3'd3;
  localparam logic [2:0] ReqCardByte = 3'd4;
  localparam logic [2:0] ReqWriteByte = 3'd5;
  localparam logic [2:0] ReqDelay = 3'd6;

  localparam logic [2:0] KindExchange = 3'd0;
  localparam logic [2:0] KindWait = 3'd1;
  localparam logic [2:0] KindNeedByte = 3'd2;
  localparam logic [2:0] KindReadData = 3'd3;
  localparam logic [2:0] KindDone = 3'd4;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatFail = 2'd1;
  localparam logic [1:0] StatNoInit = 2'd2;

  localparam logic [2:0] CardNone = 3'd0;
  localparam logic [2:0] CardMmc = 3'd1;
  localparam logic [2:0] CardSd1 = 3'd2;
  localparam logic [2:0] CardSd2Byte = 3'd3;
  localparam logic [2:0] CardSd2Block = 3'd4;

  localparam logic [1:0] RegRespLim = 2'd0;
  localparam logic [1:0] RegReadyLim = 2'd1;
  localparam logic [1:0] RegTokenLim = 2'd2;
  localparam logic [1:0] RegRetryLim = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] sector_address;
    logic [15:0] block_count;
    logic [7:0]  card_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  tx_byte;
    logic        select_active;
    logic        fast_clock;
    logic [7:0]  data_byte;
    logic        last_flag;
    logic [1:0]  status;
    logic [2:0]  card_kind;
    logic [31:0] sector_total;
  } res_t;

  typedef struct packed {
    logic [7:0]  resp_lim;
    logic [15:0] ready_lim;
    logic [15:0] token_lim;
    logic [15:0] retry_lim;
  } cfg_t;

endpackage

// ===== sv/sdsh_req_if.sv =====
interface sdsh_req_if;
  logic               valid;
  logic               ready;
  sdsh_pkg::req_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sdsh_res_if.sv =====
interface sdsh_res_if;
  logic               valid;
  logic               ready;
  sdsh_pkg::res_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sdsh_fifo.sv =====
module sdsh_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_cnt_i,
  input  sdsh_pkg::res_t                      d0_i,
  input  sdsh_pkg::res_t                      d1_i,
  input  logic                                pop_i,
  output sdsh_pkg::res_t                      head_o,
  output logic [$clog2(sdsh_pkg::FifoDepth):0] cnt_o
);
  localparam int PtrW = $clog2(sdsh_pkg::FifoDepth);

  sdsh_pkg::res_t mem_q [sdsh_pkg::FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= d0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[PtrW'(wr_q + 1'b1)] <= d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= PtrW'(wr_q + PtrW'(push_cnt_i));
      rd_q <= PtrW'(rd_q + PtrW'(pop_i));
      cnt_q <= (PtrW+1)'(cnt_q + (PtrW+1)'(push_cnt_i) - (PtrW+1)'(pop_i));
    end
  end

  assign head_o = mem_q[rd_q];
  assign cnt_o = cnt_q;
endmodule

// ===== sv/sdsh_core.sv =====
module sdsh_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           proc_i,
  input  sdsh_pkg::req_t item_i,
  input  sdsh_pkg::cfg_t cfg_i,
  output logic [1:0]     push_cnt_o,
  output sdsh_pkg::res_t res0_o,
  output sdsh_pkg::res_t res1_o
);
  localparam int BcW = sdsh_pkg::BcW;

  typedef enum logic [4:0] {
    P_IDLE, P_INIT_CLK, P_C_DESEL, P_C_SEL, P_C_READY, P_C_FRAME, P_C_RESP, P_OCR,
    P_WAIT, P_INIT_FINAL, P_TOKEN, P_RD_DATA, P_RD_CRC, P_RD_DESEL, P_WR_TOKEN,
    P_WR_NEED, P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY, P_WR_DESEL, P_CAP_DATA,
    P_CAP_CRC, P_CAP_DESEL, P_FAIL_DESEL
  } phase_e;

  typedef enum logic [3:0] {
    R_NONE, R_AFTER0, R_AFTER8, R_LOOP2, R_AFTER58, R_PROBE, R_LOOP1, R_AFTER16,
    R_RD, R_WR, R_CAP, R_TOK_RD, R_TOK_CAP
  } resume_e;

  typedef enum logic [3:0] {
    A_NONE, A_X, A_KIND, A_DONE, A_START, A_FINISH, A_FAIL, A_RETRY, A_OCR,
    A_TOKEN, A_FRAME, A_PROBE, A_RESULT
  } act_e;

  typedef struct packed {
    act_e        code;
    logic [7:0]  tx;
    logic        sel;
    phase_e      ph;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic        app;
    resume_e     ret;
    logic [2:0]  ty;
    logic [1:0]  st;
    logic [31:0] total;
    logic [7:0]  res;
  } act_t;

  phase_e phase_q, phase_d;
  resume_e resume_q, resume_d;
  logic [2:0] cc_q, cc_d;
  logic ready_q, ready_d, cf_q, cf_d, app_q, app_d;
  logic [15:0] poll_q, poll_d, retry_q, retry_d, bl_q, bl_d;
  logic [BcW-1:0] bc_q, bc_d;
  logic [31:0] ca_q, ca_d, arg_q, arg_d;
  logic [5:0] idx_q, idx_d;
  logic [7:0] rb_q [16];
  logic rb_we;
  logic [3:0] rb_idx;

  act_t a;
  logic pre_vld, e_vld;
  sdsh_pkg::res_t pre, e;
  logic [31:0] nb_addr;
  logic [7:0] b;

  function automatic act_t mk(act_e code, phase_e ph);
    act_t r;
    r = '{code: code, tx: 8'hFF, sel: 1'b0, ph: ph, idx: 6'd0, arg: 32'd0, app: 1'b0,
          ret: R_NONE, ty: 3'd0, st: 2'd0, total: 32'd0, res: 8'd0};
    return r;
  endfunction

  function automatic act_t mk_x(logic [7:0] tx, logic sel, phase_e ph);
    act_t r;
    r = mk(A_X, ph);
    r.tx = tx;
    r.sel = sel;
    return r;
  endfunction

  function automatic act_t mk_start(logic [5:0] idx, logic [31:0] arg, logic app,
                                    resume_e ret);
    act_t r;
    r = mk(A_START, P_IDLE);
    r.idx = idx;
    r.arg = arg;
    r.app = app;
    r.ret = ret;
    return r;
  endfunction

  function automatic act_t mk_ty(act_e code, logic [2:0] ty);
    act_t r;
    r = mk(code, P_IDLE);
    r.ty = ty;
    return r;
  endfunction

  function automatic act_t mk_done(logic [1:0] st, logic [31:0] total);
    act_t r;
    r = mk(A_DONE, P_IDLE);
    r.st = st;
    r.total = total;
    return r;
  endfunction

  function automatic act_t mk_token(resume_e ret);
    act_t r;
    r = mk(A_TOKEN, P_IDLE);
    r.ret = ret;
    return r;
  endfunction

  function automatic act_t cont_f(resume_e r, logic [7:0] res, logic [2:0] cc);
    act_t o;
    unique case (r)
      R_AFTER0: o = (res == 8'd1) ? mk_start(6'd8, 32'h1AA, 1'b0, R_AFTER8)
                                  : mk_ty(A_FINISH, sdsh_pkg::CardNone);
      R_AFTER8: o = (res == 8'd1) ? mk(A_OCR, P_IDLE)
                                  : mk_start(6'd41, 32'd0, 1'b1, R_PROBE);
      R_LOOP2: o = (res == 8'd0) ? mk_start(6'd58, 32'd0, 1'b0, R_AFTER58)
                                 : mk(A_RETRY, P_IDLE);
      R_AFTER58: o = (res == 8'd0) ? mk(A_OCR, P_IDLE)
                                   : mk_ty(A_FINISH, sdsh_pkg::CardNone);
      R_PROBE: o = mk_ty(A_PROBE, (res <= 8'd1) ? sdsh_pkg::CardSd1 : sdsh_pkg::CardMmc);
      R_LOOP1: o = (res == 8'd0) ? mk_start(6'd16, 32'(sdsh_pkg::BlockBytes), 1'b0, R_AFTER16)
                                 : mk(A_RETRY, P_IDLE);
      R_AFTER16: o = mk_ty(A_FINISH, (res == 8'd0) ? cc : sdsh_pkg::CardNone);
      R_RD: o = (res != 8'd0) ? mk(A_FAIL, P_IDLE) : mk_token(R_TOK_RD);
      R_CAP: o = (res != 8'd0) ? mk(A_FAIL, P_IDLE) : mk_token(R_TOK_CAP);
      R_WR: o = (res != 8'd0) ? mk(A_FAIL, P_IDLE) : mk_x(8'hFE, 1'b1, P_WR_TOKEN);
      default: o = mk(A_FAIL, P_IDLE);
    endcase
    return o;
  endfunction

  function automatic logic [7:0] frame_f(logic [2:0] i, logic app, logic [5:0] cidx,
                                         logic [31:0] carg);
    logic [5:0] idx;
    logic [31:0] arg;
    logic [7:0] r;
    idx = app ? 6'd55 : cidx;
    arg = app ? 32'd0 : carg;
    unique case (i)
      3'd0: r = {2'b01, idx};
      3'd1: r = arg[31:24];
      3'd2: r = arg[23:16];
      3'd3: r = arg[15:8];
      3'd4: r = arg[7:0];
      default: r = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] cap_f(logic [7:0] c0, logic [7:0] c5, logic [7:0] c6,
                                        logic [7:0] c7, logic [7:0] c8, logic [7:0] c9,
                                        logic [7:0] c10);
    logic [21:0] cs2;
    logic [11:0] cs1;
    logic [4:0] n;
    logic [31:0] m;
    logic [31:0] r;
    cs2 = {c7[5:0], c8, c9};
    cs1 = {c6[1:0], c7, c8[7:6]};
    n = 5'(c5[3:0]) + 5'(c10[7]) + 5'({c9[1:0], 1'b0}) + 5'd2;
    m = 32'(cs1) + 32'd1;
    if (c0[7:6] == 2'b01) begin
      r = 32'((32'(cs2) + 32'd1) << 10);
    end else if (n >= 5'd9) begin
      r = m << (n - 5'd9);
    end else begin
      r = m >> (5'd9 - n);
    end
    return r;
  endfunction

  function automatic logic [15:0] lim16(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  always_comb begin
    phase_d = phase_q;
    resume_d = resume_q;
    cc_d = cc_q;
    ready_d = ready_q;
    cf_d = cf_q;
    app_d = app_q;
    poll_d = poll_q;
    retry_d = retry_q;
    bl_d = bl_q;
    bc_d = bc_q;
    ca_d = ca_q;
    arg_d = arg_q;
    idx_d = idx_q;
    rb_we = 1'b0;
    rb_idx = bc_q[3:0];
    a = mk(A_NONE, phase_q);
    pre_vld = 1'b0;
    pre = '0;
    e_vld = 1'b0;
    e = '0;
    b = item_i.card_byte;
    nb_addr = ca_q + ((cc_q == sdsh_pkg::CardSd2Block) ? 32'd1 : 32'(sdsh_pkg::BlockBytes));

    if (proc_i) begin
      priority if (item_i.req_type <= sdsh_pkg::ReqCap) begin
        if (phase_q == P_IDLE) begin
          priority if (item_i.req_type == sdsh_pkg::ReqInit) begin
            cf_d = 1'b0;
            bc_d = '0;
            a = mk_x(8'hFF, 1'b0, P_INIT_CLK);
          end else if (!ready_q) begin
            a = mk_done(sdsh_pkg::StatNoInit, 32'd0);
          end else if (item_i.req_type == sdsh_pkg::ReqCap) begin
            a = mk_start(6'd9, 32'd0, 1'b0, R_CAP);
          end else if (item_i.block_count == 16'd0) begin
            a = mk_done(sdsh_pkg::StatOk, 32'd0);
          end else begin
            ca_d = (cc_q == sdsh_pkg::CardSd2Block) ? item_i.sector_address
                 : 32'(item_i.sector_address << sdsh_pkg::BlkShift);
            bl_d = item_i.block_count;
            a = (item_i.req_type == sdsh_pkg::ReqRead) ? mk_start(6'd17, ca_d, 1'b0, R_RD)
                                                      : mk_start(6'd24, ca_d, 1'b0, R_WR);
          end
        end
      end else if (item_i.req_type == sdsh_pkg::ReqCardByte) begin
        unique case (phase_q)
          P_INIT_CLK: begin
            bc_d = BcW'(bc_q + 1'b1);
            a = (bc_d < BcW'(10)) ? mk_x(8'hFF, 1'b0, phase_q)
                                  : mk_start(6'd0, 32'd0, 1'b0, R_AFTER0);
          end
          P_C_DESEL: a = mk_x(8'hFF, 1'b1, P_C_SEL);
          P_C_SEL: begin
            if (!cf_q) begin
              a = mk(A_FRAME, phase_q);
            end else begin
              poll_d = '0;
              a = mk_x(8'hFF, 1'b1, P_C_READY);
            end
          end
          P_C_READY: begin
            if (b == 8'hFF) begin
              a = mk(A_FRAME, phase_q);
            end else begin
              poll_d = poll_q + 16'd1;
              if (poll_d >= lim16(cfg_i.ready_lim)) begin
                a = mk(A_RESULT, phase_q);
                a.res = 8'hFF;
              end else begin
                a = mk_x(8'hFF, 1'b1, phase_q);
              end
            end
          end
          P_C_FRAME: begin
            bc_d = BcW'(bc_q + 1'b1);
            if (bc_d < BcW'(6)) begin
              a = mk_x(frame_f(bc_d[2:0], app_q, idx_q, arg_q), 1'b1, phase_q);
            end else begin
              poll_d = '0;
              a = mk_x(8'hFF, 1'b1, P_C_RESP);
            end
          end
          P_C_RESP: begin
            poll_d = poll_q + 16'd1;
            if (b[7] && (poll_d < lim16({8'd0, cfg_i.resp_lim}))) begin
              a = mk_x(8'hFF, 1'b1, phase_q);
            end else begin
              a = mk(A_RESULT, phase_q);
              a.res = b;
            end
          end
          P_OCR: begin
            rb_we = 1'b1;
            bc_d = BcW'(bc_q + 1'b1);
            if (bc_d < BcW'(4)) begin
              a = mk_x(8'hFF, 1'b1, phase_q);
            end else if (resume_q == R_AFTER8) begin
              if (rb_q[2] == 8'h01 && b == 8'hAA) begin
                retry_d = '0;
                a = mk_start(6'd41, 32'h4000_0000, 1'b1, R_LOOP2);
              end else begin
                a = mk_ty(A_FINISH, sdsh_pkg::CardNone);
              end
            end else begin
              a = mk_ty(A_FINISH, rb_q[0][6] ? sdsh_pkg::CardSd2Block : sdsh_pkg::CardSd2Byte);
            end
          end
          P_INIT_FINAL: begin
            if (cc_q != sdsh_pkg::CardNone) begin
              cf_d = 1'b1;
              ready_d = 1'b1;
              a = mk_done(sdsh_pkg::StatOk, 32'd0);
            end else begin
              ready_d = 1'b0;
              a = mk_done(sdsh_pkg::StatFail, 32'd0);
            end
          end
          P_TOKEN: begin
            if (b == 8'hFF) begin
              poll_d = poll_q + 16'd1;
              a = (poll_d < lim16(cfg_i.token_lim)) ? mk_x(8'hFF, 1'b1, phase_q)
                                                     : mk(A_FAIL, phase_q);
            end else if (b != 8'hFE) begin
              a = mk(A_FAIL, phase_q);
            end else begin
              bc_d = '0;
              a = mk_x(8'hFF, 1'b1, (resume_q == R_TOK_CAP) ? P_CAP_DATA : P_RD_DATA);
            end
          end
          P_RD_DATA: begin
            pre_vld = 1'b1;
            pre.result_kind = sdsh_pkg::KindReadData;
            pre.data_byte = b;
            pre.last_flag = (bl_q == 16'd1) && (bc_q == BcW'(sdsh_pkg::BlockBytes - 1));
            bc_d = BcW'(bc_q + 1'b1);
            if (bc_d >= BcW'(sdsh_pkg::BlockBytes)) begin
              bc_d = '0;
              a = mk_x(8'hFF, 1'b1, P_RD_CRC);
            end else begin
              a = mk_x(8'hFF, 1'b1, phase_q);
            end
          end
          P_RD_CRC, P_CAP_CRC: begin
            bc_d = BcW'(bc_q + 1'b1);
            if (bc_d < BcW'(2)) begin
              a = mk_x(8'hFF, 1'b1, phase_q);
            end else begin
              a = mk_x(8'hFF, 1'b0, (phase_q == P_RD_CRC) ? P_RD_DESEL : P_CAP_DESEL);
            end
          end
          P_RD_DESEL, P_WR_DESEL: begin
            bl_d = bl_q - 16'd1;
            ca_d = nb_addr;
            if (bl_d == 16'd0) begin
              a = mk_done(sdsh_pkg::StatOk, 32'd0);
            end else if (phase_q == P_RD_DESEL) begin
              a = mk_start(6'd17, nb_addr, 1'b0, R_RD);
            end else begin
              a = mk_start(6'd24, nb_addr, 1'b0, R_WR);
            end
          end
          P_CAP_DATA: begin
            rb_we = 1'b1;
            bc_d = BcW'(bc_q + 1'b1);
            if (bc_d >= BcW'(16)) begin
              bc_d = '0;
              a = mk_x(8'hFF, 1'b1, P_CAP_CRC);
            end else begin
              a = mk_x(8'hFF, 1'b1, phase_q);
            end
          end
          P_CAP_DESEL: begin
            a = mk_done(sdsh_pkg::StatOk,
                        cap_f(rb_q[0], rb_q[5], rb_q[6], rb_q[7], rb_q[8], rb_q[9], rb_q[10]));
          end
          P_WR_TOKEN: begin
            bc_d = '0;
            a = mk(A_KIND, P_WR_NEED);
          end
          P_WR_DATA: begin
            bc_d = BcW'(bc_q + 1'b1);
            if (bc_d < BcW'(sdsh_pkg::BlockBytes)) begin
              a = mk(A_KIND, P_WR_NEED);
            end else begin
              bc_d = '0;
              a = mk_x(8'hFF, 1'b1, P_WR_CRC);
            end
          end
          P_WR_CRC: begin
            bc_d = BcW'(bc_q + 1'b1);
            a = mk_x(8'hFF, 1'b1, (bc_d >= BcW'(2)) ? P_WR_RESP : phase_q);
          end
          P_WR_RESP: begin
            a = (b[4:0] != 5'h05) ? mk(A_FAIL, phase_q) : mk_x(8'hFF, 1'b1, P_WR_BUSY);
          end
          P_WR_BUSY: begin
            a = (b == 8'h00) ? mk_x(8'hFF, 1'b1, phase_q) : mk_x(8'hFF, 1'b0, P_WR_DESEL);
          end
          P_FAIL_DESEL: a = mk_done(sdsh_pkg::StatFail, 32'd0);
          default: a = mk(A_NONE, phase_q);
        endcase
      end else if (item_i.req_type == sdsh_pkg::ReqWriteByte) begin
        if (phase_q == P_WR_NEED) begin
          a = mk_x(item_i.write_byte, 1'b1, P_WR_DATA);
        end
      end else if (item_i.req_type == sdsh_pkg::ReqDelay) begin
        if (phase_q == P_WAIT) begin
          priority if (retry_q >= lim16(cfg_i.retry_lim)) begin
            a = mk_ty(A_FINISH, sdsh_pkg::CardNone);
          end else if (resume_q == R_LOOP2) begin
            a = mk_start(6'd41, 32'h4000_0000, 1'b1, R_LOOP2);
          end else if (cc_q == sdsh_pkg::CardSd1) begin
            a = mk_start(6'd41, 32'd0, 1'b1, R_LOOP1);
          end else begin
            a = mk_start(6'd1, 32'd0, 1'b0, R_LOOP1);
          end
        end
      end
    end

    if (a.code == A_RESULT) begin
      if (app_q) begin
        app_d = 1'b0;
        a = (a.res > 8'd1) ? cont_f(resume_q, a.res, cc_q) : mk_x(8'hFF, 1'b0, P_C_DESEL);
      end else begin
        a = cont_f(resume_q, a.res, cc_q);
      end
    end

    unique case (a.code)
      A_X: begin
        phase_d = a.ph;
        e_vld = 1'b1;
        e.tx_byte = a.tx;
        e.select_active = a.sel;
      end
      A_KIND: begin
        phase_d = a.ph;
        e_vld = 1'b1;
        e.result_kind = sdsh_pkg::KindNeedByte;
      end
      A_DONE: begin
        phase_d = P_IDLE;
        e_vld = 1'b1;
        e.result_kind = sdsh_pkg::KindDone;
        e.status = a.st;
        e.sector_total = a.total;
      end
      A_START, A_PROBE: begin
        if (a.code == A_PROBE) begin
          cc_d = a.ty;
          retry_d = '0;
          idx_d = (a.ty == sdsh_pkg::CardSd1) ? 6'd41 : 6'd1;
          app_d = (a.ty == sdsh_pkg::CardSd1);
          arg_d = 32'd0;
          resume_d = R_LOOP1;
        end else begin
          idx_d = a.idx;
          arg_d = a.arg;
          app_d = a.app;
          resume_d = a.ret;
        end
        phase_d = P_C_DESEL;
        e_vld = 1'b1;
        e.tx_byte = 8'hFF;
      end
      A_FINISH: begin
        cc_d = a.ty;
        phase_d = P_INIT_FINAL;
        e_vld = 1'b1;
        e.tx_byte = 8'hFF;
      end
      A_FAIL: begin
        phase_d = P_FAIL_DESEL;
        e_vld = 1'b1;
        e.tx_byte = 8'hFF;
      end
      A_RETRY: begin
        retry_d = retry_q + 16'd1;
        phase_d = P_WAIT;
        e_vld = 1'b1;
        e.result_kind = sdsh_pkg::KindWait;
      end
      A_OCR: begin
        bc_d = '0;
        phase_d = P_OCR;
        e_vld = 1'b1;
        e.tx_byte = 8'hFF;
        e.select_active = 1'b1;
      end
      A_TOKEN: begin
        poll_d = '0;
        resume_d = a.ret;
        phase_d = P_TOKEN;
        e_vld = 1'b1;
        e.tx_byte = 8'hFF;
        e.select_active = 1'b1;
      end
      A_FRAME: begin
        bc_d = '0;
        phase_d = P_C_FRAME;
        e_vld = 1'b1;
        e.tx_byte = frame_f(3'd0, app_q, idx_q, arg_q);
        e.select_active = 1'b1;
      end
      default: e_vld = 1'b0;
    endcase

    if (a.code == A_X || a.code == A_START || a.code == A_PROBE || a.code == A_FINISH ||
        a.code == A_FAIL || a.code == A_OCR || a.code == A_TOKEN || a.code == A_FRAME) begin
      e.fast_clock = cf_d;
    end
    if (a.code == A_DONE) begin
      e.card_kind = cc_d;
    end

    if (pre_vld) begin
      res0_o = pre;
      res1_o = e;
      push_cnt_o = e_vld ? 2'd2 : 2'd1;
    end else begin
      res0_o = e;
      res1_o = pre;
      push_cnt_o = {1'b0, e_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rb_we) begin
      rb_q[rb_idx] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      resume_q <= R_NONE;
      cc_q <= sdsh_pkg::CardNone;
      ready_q <= 1'b0;
      cf_q <= 1'b0;
      app_q <= 1'b0;
      poll_q <= '0;
      retry_q <= '0;
      bl_q <= '0;
      bc_q <= '0;
      ca_q <= '0;
      arg_q <= '0;
      idx_q <= '0;
    end else begin
      phase_q <= phase_d;
      resume_q <= resume_d;
      cc_q <= cc_d;
      ready_q <= ready_d;
      cf_q <= cf_d;
      app_q <= app_d;
      poll_q <= poll_d;
      retry_q <= retry_d;
      bl_q <= bl_d;
      bc_q <= bc_d;
      ca_q <= ca_d;
      arg_q <= arg_d;
      idx_q <= idx_d;
    end
  end
endmodule

// ===== sv/sd_card_spi_host_sequencer.sv =====
// SPI-mode SD card host sequencer.
// Requests and byte handshakes arrive on req_i; every transaction is one
// request (init, read, write, capacity) or one answer from the host (card
// byte, write byte, delay elapsed). Results leave on res_o: a byte to
// exchange on the bus, a wait, a request for the next write byte,
// a read data byte, or a done with status, card kind and capacity.
// A transaction is taken into an input register and processed once the
// result queue has room for its results, which are then queued; res_o
// shows the head of the result queue.
// One transaction is taken every cycle while the four-entry result queue has
// room for two more entries, so the rate is one transaction per cycle,
// limited by the result queue when a read data byte and an exchange are
// both produced. A stalled receiver fills the queue, and req_i.ready then
// drops until results are taken.
// Reset leaves the card uninitialized, in slow clock mode, with default
// poll and retry limits. The user must write limits over the APB port only while idle, unchecked by the block.
module sd_card_spi_host_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdsh_req_if.sink    req_i,
  sdsh_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CntW = $clog2(sdsh_pkg::FifoDepth) + 1;

  sdsh_pkg::cfg_t cfg_q;
  sdsh_pkg::req_t item_q;
  logic iv_q, proc, accept, pop;
  logic [1:0] push_cnt;
  sdsh_pkg::res_t res0, res1;
  logic [CntW-1:0] cnt;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{resp_lim: 8'd10, ready_lim: 16'd50000, token_lim: 16'd40000,
                 retry_lim: 16'd10000};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        sdsh_pkg::RegRespLim: cfg_q.resp_lim <= pwdata[7:0];
        sdsh_pkg::RegReadyLim: cfg_q.ready_lim <= pwdata[15:0];
        sdsh_pkg::RegTokenLim: cfg_q.token_lim <= pwdata[15:0];
        default: cfg_q.retry_lim <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sdsh_pkg::RegRespLim: prdata = {24'd0, cfg_q.resp_lim};
      sdsh_pkg::RegReadyLim: prdata = {16'd0, cfg_q.ready_lim};
      sdsh_pkg::RegTokenLim: prdata = {16'd0, cfg_q.token_lim};
      default: prdata = {16'd0, cfg_q.retry_lim};
    endcase
  end

  assign proc = iv_q && (cnt <= CntW'(sdsh_pkg::FifoDepth - 2));
  assign req_i.ready = !iv_q || proc;
  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (accept) begin
      iv_q <= 1'b1;
    end else if (proc) begin
      iv_q <= 1'b0;
    end
  end

  sdsh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .proc_i     (proc),
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .push_cnt_o (push_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  assign res_o.valid = (cnt != '0);
  assign pop = res_o.valid && res_o.ready;

  sdsh_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .d0_i       (res0),
    .d1_i       (res1),
    .pop_i      (pop),
    .head_o     (res_o.data),
    .cnt_o      (cnt)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CntW'(sdsh_pkg::FifoDepth))
    else $error("result queue overflow");

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iv_q && !proc) |=> (iv_q && $stable(item_q)))
    else $error("pending transaction lost");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt != 2'd0) |-> proc)
    else $error("results produced without a transaction");
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sdsh_pkg::*;

  localparam logic [2:0] ReqNone = 3'd7;
  localparam int unsigned CycleLimit = 3000000;

  localparam logic [5:0] CmdGoIdle = 6'd0;
  localparam logic [5:0] CmdSendOp = 6'd1;
  localparam logic [5:0] CmdIfCond = 6'd8;
  localparam logic [5:0] CmdSendCsd = 6'd9;
  localparam logic [5:0] CmdSetLen = 6'd16;
  localparam logic [5:0] CmdReadBlk = 6'd17;
  localparam logic [5:0] CmdWriteBlk = 6'd24;
  localparam logic [5:0] CmdAppOp = 6'd41;
  localparam logic [5:0] CmdAppPrefix = 6'd55;
  localparam logic [5:0] CmdReadOcr = 6'd58;

  localparam logic [31:0] ArgIfCond = 32'h0000_01AA;
  localparam logic [31:0] ArgHcs = 32'h4000_0000;
  localparam logic [7:0] ByteIdle = 8'hFF;
  localparam logic [7:0] TokStart = 8'hFE;
  localparam logic [7:0] RespIdle = 8'h01;
  localparam logic [7:0] RespReady = 8'h00;
  localparam logic [7:0] RespIllegal = 8'h05;
  localparam logic [4:0] WrAccepted = 5'h05;

  typedef enum int {
    StIdle, StInitClk, StCDesel, StCSel, StCReady, StCFrame, StCResp, StOcr, StWait,
    StInitFinal, StToken, StRdData, StRdCrc, StRdDesel, StWrToken, StWrNeed, StWrData,
    StWrCrc, StWrResp, StWrBusy, StWrDesel, StCapData, StCapCrc, StCapDesel, StFailDesel,
    StAfter0, StAfter8, StLoop2, StAfter58, StProbe, StLoop1, StAfter16, StRd, StWr, StCap
  } step_e;

  class sd_host_scoreboard;
    logic [7:0] resp_lim;
    logic [15:0] ready_lim, token_lim, retry_lim;
    step_e phase, resume;
    logic [2:0] card_class;
    bit card_ready, clock_fast, app_pending;
    int unsigned poll_cnt, byte_cnt;
    logic [15:0] retry_cnt, blocks_left;
    logic [31:0] cur_addr, cmd_arg;
    logic [5:0] cmd_idx;
    logic [7:0] reg_bytes [16];
    res_t expected_q[$];
    int errors;

    function new();
      resp_lim = 8'd10;
      ready_lim = 16'd50000;
      token_lim = 16'd40000;
      retry_lim = 16'd10000;
      phase = StIdle;
      resume = StIdle;
      card_class = CardNone;
      card_ready = 0;
      clock_fast = 0;
      app_pending = 0;
      poll_cnt = 0;
      byte_cnt = 0;
      retry_cnt = '0;
      blocks_left = '0;
      cur_addr = '0;
      cmd_arg = '0;
      cmd_idx = '0;
      foreach (reg_bytes[i]) reg_bytes[i] = '0;
      errors = 0;
    endfunction

    function int unsigned lim(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function void set_limit(logic [1:0] idx, logic [31:0] v);
      case (idx)
        RegRespLim: resp_lim = v[7:0];
        RegReadyLim: ready_lim = v[15:0];
        RegTokenLim: token_lim = v[15:0];
        default: retry_lim = v[15:0];
      endcase
    endfunction

    function void push_exch(logic [7:0] tx, bit sel);
      res_t r;
      r = '0;
      r.result_kind = KindExchange;
      r.tx_byte = tx;
      r.select_active = sel;
      r.fast_clock = clock_fast;
      expected_q.push_back(r);
    endfunction

    function void push_kind(logic [2:0] k);
      res_t r;
      r = '0;
      r.result_kind = k;
      expected_q.push_back(r);
    endfunction

    function void push_data(logic [7:0] b, bit last);
      res_t r;
      r = '0;
      r.result_kind = KindReadData;
      r.data_byte = b;
      r.last_flag = last;
      expected_q.push_back(r);
    endfunction

    function void push_done(logic [1:0] st, logic [31:0] total);
      res_t r;
      r = '0;
      r.result_kind = KindDone;
      r.status = st;
      r.card_kind = card_class;
      r.sector_total = total;
      expected_q.push_back(r);
      phase = StIdle;
    endfunction

    function void start_cmd(logic [5:0] idx, logic [31:0] arg, bit app, step_e ret);
      cmd_idx = idx;
      cmd_arg = arg;
      app_pending = app;
      resume = ret;
      phase = StCDesel;
      push_exch(ByteIdle, 0);
    endfunction

    function logic [7:0] frame_byte(int unsigned i);
      logic [5:0] idx;
      logic [31:0] arg;
      idx = app_pending ? CmdAppPrefix : cmd_idx;
      arg = app_pending ? 32'h0 : cmd_arg;
      if (i == 0) return {2'b01, idx};
      if (i <= 4) return 8'(arg >> (8 * (4 - i)));
      if (idx == CmdGoIdle) return 8'h95;
      if (idx == CmdIfCond) return 8'h87;
      return 8'h01;
    endfunction

    function void init_finish(logic [2:0] ty);
      card_class = ty;
      phase = StInitFinal;
      push_exch(ByteIdle, 0);
    endfunction

    function void fail_desel();
      phase = StFailDesel;
      push_exch(ByteIdle, 0);
    endfunction

    function void retry_wait();
      retry_cnt = retry_cnt + 16'd1;
      phase = StWait;
      push_kind(KindWait);
    endfunction

    function void loop1_issue();
      if (card_class == CardSd1) start_cmd(CmdAppOp, '0, 1, StLoop1);
      else start_cmd(CmdSendOp, '0, 0, StLoop1);
    endfunction

    function void start_reg_read();
      byte_cnt = 0;
      phase = StOcr;
      push_exch(ByteIdle, 1);
    endfunction

    function void token_wait(step_e target);
      poll_cnt = 0;
      resume = target;
      phase = StToken;
      push_exch(ByteIdle, 1);
    endfunction

    function void begin_frame();
      byte_cnt = 0;
      phase = StCFrame;
      push_exch(frame_byte(0), 1);
    endfunction

    function void cont(logic [7:0] res);
      case (resume)
        StAfter0: begin
          if (res == 1) start_cmd(CmdIfCond, ArgIfCond, 0, StAfter8);
          else init_finish(CardNone);
        end
        StAfter8: begin
          if (res == 1) start_reg_read();
          else start_cmd(CmdAppOp, '0, 1, StProbe);
        end
        StLoop2: begin
          if (res == 0) start_cmd(CmdReadOcr, '0, 0, StAfter58);
          else retry_wait();
        end
        StAfter58: begin
          if (res == 0) start_reg_read();
          else init_finish(CardNone);
        end
        StProbe: begin
          card_class = (res <= 1) ? CardSd1 : CardMmc;
          retry_cnt = '0;
          loop1_issue();
        end
        StLoop1: begin
          if (res == 0) start_cmd(CmdSetLen, 32'(BlockBytes), 0, StAfter16);
          else retry_wait();
        end
        StAfter16: init_finish((res == 0) ? card_class : CardNone);
        StRd: begin
          if (res != 0) fail_desel();
          else token_wait(StRdData);
        end
        StCap: begin
          if (res != 0) fail_desel();
          else token_wait(StCapData);
        end
        StWr: begin
          if (res != 0) begin
            fail_desel();
          end else begin
            phase = StWrToken;
            push_exch(TokStart, 1);
          end
        end
        default: fail_desel();
      endcase
    endfunction

    function void cmd_result(logic [7:0] res);
      if (app_pending) begin
        app_pending = 0;
        if (res > 1) begin
          cont(res);
        end else begin
          phase = StCDesel;
          push_exch(ByteIdle, 0);
        end
      end else begin
        cont(res);
      end
    endfunction

    function void next_block(logic [5:0] idx, step_e ret);
      blocks_left = blocks_left - 16'd1;
      cur_addr = cur_addr + ((card_class == CardSd2Block) ? 32'd1 : 32'(BlockBytes));
      if (blocks_left == 0) push_done(StatOk, '0);
      else start_cmd(idx, cur_addr, 0, ret);
    endfunction

    function logic [31:0] capacity();
      logic [31:0] cs;
      int unsigned n;
      if (reg_bytes[0][7:6] == 2'b01) begin
        cs = {10'd0, reg_bytes[7][5:0], reg_bytes[8], reg_bytes[9]};
        return (cs + 32'd1) * 32'd1024;
      end
      n = reg_bytes[5][3:0] + reg_bytes[10][7] + (reg_bytes[9][1:0] << 1) + 2;
      cs = {20'd0, reg_bytes[6][1:0], reg_bytes[7], reg_bytes[8][7:6]};
      if (n >= 9) return (cs + 32'd1) << (n - 9);
      return (cs + 32'd1) >> (9 - n);
    endfunction

    function void on_start(logic [2:0] req, logic [31:0] sector, logic [15:0] count);
      if (req == ReqInit) begin
        clock_fast = 0;
        byte_cnt = 0;
        phase = StInitClk;
        push_exch(ByteIdle, 0);
      end else if (!card_ready) begin
        push_done(StatNoInit, '0);
      end else if (req == ReqCap) begin
        start_cmd(CmdSendCsd, '0, 0, StCap);
      end else if (count == 0) begin
        push_done(StatOk, '0);
      end else begin
        cur_addr = (card_class == CardSd2Block) ? sector : (sector << BlkShift);
        blocks_left = count;
        if (req == ReqRead) start_cmd(CmdReadBlk, cur_addr, 0, StRd);
        else start_cmd(CmdWriteBlk, cur_addr, 0, StWr);
      end
    endfunction

    function void on_byte(logic [7:0] b);
      case (phase)
        StInitClk: begin
          byte_cnt++;
          if (byte_cnt < 10) push_exch(ByteIdle, 0);
          else start_cmd(CmdGoIdle, '0, 0, StAfter0);
        end
        StCDesel: begin
          phase = StCSel;
          push_exch(ByteIdle, 1);
        end
        StCSel: begin
          if (!clock_fast) begin
            begin_frame();
          end else begin
            poll_cnt = 0;
            phase = StCReady;
            push_exch(ByteIdle, 1);
          end
        end
        StCReady: begin
          if (b == ByteIdle) begin
            begin_frame();
          end else begin
            poll_cnt++;
            if (poll_cnt >= lim(ready_lim)) cmd_result(ByteIdle);
            else push_exch(ByteIdle, 1);
          end
        end
        StCFrame: begin
          byte_cnt++;
          if (byte_cnt < 6) begin
            push_exch(frame_byte(byte_cnt), 1);
          end else begin
            poll_cnt = 0;
            phase = StCResp;
            push_exch(ByteIdle, 1);
          end
        end
        StCResp: begin
          poll_cnt++;
          if (b[7] && poll_cnt < lim(resp_lim)) push_exch(ByteIdle, 1);
          else cmd_result(b);
        end
        StOcr: begin
          reg_bytes[byte_cnt & 15] = b;
          byte_cnt++;
          if (byte_cnt < 4) begin
            push_exch(ByteIdle, 1);
          end else if (resume == StAfter8) begin
            if (reg_bytes[2] == 8'h01 && reg_bytes[3] == 8'hAA) begin
              retry_cnt = '0;
              start_cmd(CmdAppOp, ArgHcs, 1, StLoop2);
            end else begin
              init_finish(CardNone);
            end
          end else begin
            init_finish(reg_bytes[0][6] ? CardSd2Block : CardSd2Byte);
          end
        end
        StInitFinal: begin
          if (card_class != CardNone) begin
            clock_fast = 1;
            card_ready = 1;
          end else begin
            card_ready = 0;
          end
          push_done((card_class != CardNone) ? StatOk : StatFail, '0);
        end
        StToken: begin
          if (b == ByteIdle) begin
            poll_cnt++;
            if (poll_cnt < lim(token_lim)) push_exch(ByteIdle, 1);
            else fail_desel();
          end else if (b != TokStart) begin
            fail_desel();
          end else begin
            byte_cnt = 0;
            phase = resume;
            push_exch(ByteIdle, 1);
          end
        end
        StRdData: begin
          push_data(b, blocks_left == 1 && byte_cnt == BlockBytes - 1);
          byte_cnt++;
          if (byte_cnt >= BlockBytes) begin
            byte_cnt = 0;
            phase = StRdCrc;
          end
          push_exch(ByteIdle, 1);
        end
        StRdCrc, StCapCrc: begin
          byte_cnt++;
          if (byte_cnt < 2) begin
            push_exch(ByteIdle, 1);
          end else begin
            phase = (phase == StRdCrc) ? StRdDesel : StCapDesel;
            push_exch(ByteIdle, 0);
          end
        end
        StRdDesel: next_block(CmdReadBlk, StRd);
        StCapData: begin
          reg_bytes[byte_cnt & 15] = b;
          byte_cnt++;
          if (byte_cnt >= 16) begin
            byte_cnt = 0;
            phase = StCapCrc;
          end
          push_exch(ByteIdle, 1);
        end
        StCapDesel: push_done(StatOk, capacity());
        StWrToken: begin
          byte_cnt = 0;
          phase = StWrNeed;
          push_kind(KindNeedByte);
        end
        StWrData: begin
          byte_cnt++;
          if (byte_cnt < BlockBytes) begin
            phase = StWrNeed;
            push_kind(KindNeedByte);
          end else begin
            byte_cnt = 0;
            phase = StWrCrc;
            push_exch(ByteIdle, 1);
          end
        end
        StWrCrc: begin
          byte_cnt++;
          if (byte_cnt >= 2) phase = StWrResp;
          push_exch(ByteIdle, 1);
        end
        StWrResp: begin
          if (b[4:0] != WrAccepted) begin
            fail_desel();
          end else begin
            phase = StWrBusy;
            push_exch(ByteIdle, 1);
          end
        end
        StWrBusy: begin
          if (b == 8'h00) begin
            push_exch(ByteIdle, 1);
          end else begin
            phase = StWrDesel;
            push_exch(ByteIdle, 0);
          end
        end
        StWrDesel: next_block(CmdWriteBlk, StWr);
        StFailDesel: push_done(StatFail, '0);
        default: ;
      endcase
    endfunction

    function void note_request(req_t x);
      case (x.req_type)
        ReqInit, ReqRead, ReqWrite, ReqCap: begin
          if (phase == StIdle) on_start(x.req_type, x.sector_address, x.block_count);
        end
        ReqCardByte: on_byte(x.card_byte);
        ReqWriteByte: begin
          if (phase == StWrNeed) begin
            phase = StWrData;
            push_exch(x.write_byte, 1);
          end
        end
        ReqDelay: begin
          if (phase == StWait) begin
            if (retry_cnt >= lim(retry_lim)) init_finish(CardNone);
            else if (resume == StLoop2) start_cmd(CmdAppOp, ArgHcs, 1, StLoop2);
            else loop1_issue();
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        return;
      end
      e = expected_q.pop_front();
      compare("result_kind", e.result_kind, a.result_kind);
      compare("tx_byte", e.tx_byte, a.tx_byte);
      compare("select_active", e.select_active, a.select_active);
      compare("fast_clock", e.fast_clock, a.fast_clock);
      compare("data_byte", e.data_byte, a.data_byte);
      compare("last_flag", e.last_flag, a.last_flag);
      compare("status", e.status, a.status);
      compare("card_kind", e.card_kind, a.card_kind);
      compare("sector_total", e.sector_total, a.sector_total);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int unsigned cycles;
  bit tx_burst, rx_burst;
  logic [2:0] card_profile;
  sd_host_scoreboard sb;

  sdsh_req_if req_bus ();
  sdsh_res_if res_bus ();

  sd_card_spi_host_sequencer dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .req_i(req_bus),
    .res_o(res_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // The receiver takes results on its own and checks them in order.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap(rx_burst);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (res_bus.valid !== 1'b1);
      sb.check_result(res_bus.data);
    end
  end

  // Models the card: answers each exchange mostly as a card of the chosen kind would, with random bytes mixed in.
  function logic [7:0] card_reply();
    logic [5:0] eff;
    logic [7:0] rnd;
    rnd = 8'($urandom);
    case (sb.phase)
      StCReady: return ($urandom_range(0, 3) != 0) ? ByteIdle : rnd;
      StCResp: begin
        if ($urandom_range(0, 3) == 0) return rnd | 8'h80;
        if ($urandom_range(0, 15) == 0) return rnd;
        eff = sb.app_pending ? CmdAppPrefix : sb.cmd_idx;
        case (eff)
          CmdGoIdle: return (card_profile == CardNone) ? 8'($urandom_range(2, 255)) : RespIdle;
          CmdAppPrefix: return (card_profile == CardMmc) ? RespIllegal : RespIdle;
          CmdIfCond: return (card_profile >= CardSd2Byte) ? RespIdle : RespIllegal;
          CmdAppOp, CmdSendOp: begin
            if (sb.resume == StProbe) return (card_profile == CardSd1) ? RespIdle : RespIllegal;
            return ($urandom_range(0, 2) == 0) ? RespIdle : RespReady;
          end
          default: return RespReady;
        endcase
      end
      StOcr: begin
        if ($urandom_range(0, 15) == 0) return rnd;
        if (sb.resume == StAfter8) begin
          if (sb.byte_cnt == 2) return 8'h01;
          if (sb.byte_cnt == 3) return 8'hAA;
          return 8'h00;
        end
        if (sb.byte_cnt == 0) return (card_profile == CardSd2Block) ? 8'hC0 : 8'h80;
        return rnd;
      end
      StToken: begin
        case ($urandom_range(0, 9))
          0, 1, 2: return ByteIdle;
          9: return rnd;
          default: return TokStart;
        endcase
      end
      StWrResp: return ($urandom_range(0, 7) == 0) ? rnd : {rnd[7:5], WrAccepted};
      StWrBusy: return ($urandom_range(0, 1) == 0) ? 8'h00 : rnd;
      default: return rnd;
    endcase
  endfunction

  function req_t random_req();
    req_t x;
    x.req_type = ReqNone;
    x.sector_address = $urandom;
    x.block_count = 16'($urandom);
    x.card_byte = 8'($urandom);
    x.write_byte = 8'($urandom);
    return x;
  endfunction

  function req_t next_item();
    req_t x;
    int unsigned r;
    x = random_req();
    case (sb.phase)
      StIdle: begin
        if (!sb.card_ready && $urandom_range(0, 3) != 0) x.req_type = ReqInit;
        else x.req_type = 3'($urandom_range(0, 3));
        if (x.req_type == ReqInit) card_profile = 3'($urandom_range(0, 4));
        r = $urandom_range(0, 9);
        x.block_count = (r == 0) ? 16'd0 : (r == 9) ? 16'd2 : 16'd1;
        r = $urandom_range(0, 7);
        if (r == 0) x.sector_address = '0;
        else if (r == 1) x.sector_address = '1;
      end
      StWrNeed: x.req_type = ReqWriteByte;
      StWait: x.req_type = ReqDelay;
      default: begin
        x.req_type = ReqCardByte;
        x.card_byte = card_reply();
      end
    endcase
    return x;
  endfunction

  // A transaction the block must drop: a busy request, a misplaced handshake or an unused code.
  function req_t noise_item();
    req_t x;
    x = random_req();
    x.req_type = 3'($urandom_range(0, 7));
    if (sb.phase == StIdle && x.req_type <= ReqCap) x.req_type = ReqNone;
    if (x.req_type == ReqCardByte && !(sb.phase inside {StWrNeed, StWait, StIdle}))
      x.req_type = ReqNone;
    if (x.req_type == ReqWriteByte && sb.phase == StWrNeed) x.req_type = ReqNone;
    if (x.req_type == ReqDelay && sb.phase == StWait) x.req_type = ReqNone;
    return x;
  endfunction

  task automatic send(req_t x);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data <= x;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    sb.note_request(x);
  endtask

  task automatic finish_request();
    while (sb.phase != StIdle) send(next_item());
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned n;
    n = 0;
    while (n < budget || sb.phase != StIdle) begin
      if ($urandom_range(0, 24) == 0) begin
        send(noise_item());
      end else begin
        send(next_item());
        n++;
      end
    end
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_limit(idx, v);
    @(posedge clk);
  endtask

  task automatic set_limits(logic [7:0] rl, logic [15:0] yl, logic [15:0] tl, logic [15:0] il);
    apb_write(RegRespLim, {24'd0, rl});
    apb_write(RegReadyLim, {16'd0, yl});
    apb_write(RegTokenLim, {16'd0, tl});
    apb_write(RegRetryLim, {16'd0, il});
  endtask

  initial begin
    req_t x;
    sb = new();
    cycles = 0;
    tx_burst = 0;
    rx_burst = 0;
    card_profile = CardSd2Block;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    res_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests before the card is initialized, then stray handshakes while idle.
    x = random_req();
    x.req_type = ReqRead;
    send(x);
    x = random_req();
    x.req_type = ReqWrite;
    x.sector_address = '1;
    x.block_count = '1;
    send(x);
    x = random_req();
    x.req_type = ReqCap;
    x.sector_address = '0;
    x.block_count = '0;
    send(x);
    for (int i = 0; i < 4; i++) begin
      x = random_req();
      x.req_type = (i == 0) ? ReqCardByte : (i == 1) ? ReqWriteByte : (i == 2) ? ReqDelay : ReqNone;
      send(x);
    end
    x = random_req();
    x.req_type = ReqInit;
    card_profile = CardSd2Block;
    send(x);
    finish_request();
    x = random_req();
    x.req_type = ReqRead;
    x.block_count = '0;
    send(x);
    run_random(150);

    wait_idle();
    set_limits(8'd255, 16'd65535, 16'd65535, 16'd65535);
    run_random(170);
    wait_idle();
    set_limits(8'd1, 16'd1, 16'd1, 16'd1);
    run_random(170);
    wait_idle();
    set_limits(8'd0, 16'd0, 16'd0, 16'd0);
    run_random(170);
    wait_idle();
    set_limits(8'($urandom_range(1, 12)), 16'($urandom_range(1, 4)),
               16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)));
    run_random(170);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
